// ===== design/srad_pkg.sv =====
// Shared types, codes and constants of the sorted range address decoder.
package srad_pkg;

  localparam int unsigned MAP_ENTRIES = 16;
  localparam int unsigned IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
  localparam logic [31:0] RAM_SIZE_RST = 32'h0100_0000;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ADD_MAP = 2'd2,
    OP_RSVD    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_OVERLAP    = 3'd2,
    ST_BAD_RANGE  = 3'd3,
    ST_NOT_MAPPED = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_RESOLVE = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [31:0] range_lo;
    logic [31:0] range_hi;
    logic [7:0]  device_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        to_device;
    logic [7:0]  target_tag;
    logic [3:0]  entry_index;
    logic [31:0] route_address;
    logic [1:0]  route_size;
    logic        route_write;
    logic [31:0] route_data;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic commit;
    logic reinit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic drop;
  } dp_sts_t;

endpackage

// ===== design/srad_ctrl.sv =====
// Controller of the decoder: item sequencing, output valid and config handshake.
module srad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  srad_pkg::dp_sts_t   sts_i,
  output srad_pkg::ctrl_cmd_t cmd_o
);

  srad_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic idle;
  logic out_free;

  assign idle        = (state_q == srad_pkg::S_IDLE);
  assign cfg_ready_o = idle;
  // a config write wins over a new word in the same cycle
  assign in_stall_o  = !idle || cfg_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign cmd_o.reinit = cfg_valid_i && idle;
  assign cmd_o.load   = in_valid_i && !in_stall_o;
  assign cmd_o.commit = (state_q == srad_pkg::S_RESOLVE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      srad_pkg::S_IDLE: begin
        if (cmd_o.load) state_d = srad_pkg::S_RESOLVE;
      end
      srad_pkg::S_RESOLVE: begin
        if (cmd_o.commit) state_d = srad_pkg::S_IDLE;
      end
      default: state_d = srad_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit && !sts_i.drop) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srad_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/srad_dp.sv =====
// Datapath of the decoder: map table, parallel bound compare, priority resolve.
module srad_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srad_pkg::ctrl_cmd_t cmd_i,
  output srad_pkg::dp_sts_t   sts_o,
  input  srad_pkg::in_item_t  in_item_i,
  input  logic [31:0]         cfg_data_i,
  output srad_pkg::out_item_t out_item_o
);

  localparam int unsigned N = srad_pkg::MAP_ENTRIES;
  localparam int unsigned IW = srad_pkg::IDX_W;

  logic [31:0] ram_bound_q [N];
  logic [31:0] dev_bound_q [N];
  logic [7:0]  tag_q       [N];

  srad_pkg::in_item_t  item_q;
  srad_pkg::out_item_t out_q, out_d;

  logic [N-1:0] ram_hit_q, ram_hit_d;
  logic [N-1:0] dev_hit_q, dev_hit_d;
  logic [N-1:0] hi_ok_q, hi_ok_d;
  logic [31:0]  key;

  // compare the incoming word against every entry at once
  assign key = (in_item_i.opcode == srad_pkg::OP_ADD_MAP) ? in_item_i.range_lo
                                                           : in_item_i.address;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ram_hit_d[i] = (key <= ram_bound_q[i]);
      dev_hit_d[i] = (key <= dev_bound_q[i]);
      hi_ok_d[i]   = (in_item_i.range_hi <= ram_bound_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q    <= in_item_i;
      ram_hit_q <= ram_hit_d;
      dev_hit_q <= dev_hit_d;
      hi_ok_q   <= hi_ok_d;
    end
  end

  // first covering entry
  logic [N-1:0] hit, first_oh, below, above;
  logic         any_hit, via_ram, hi_fits, table_full, insert_ok;
  logic [IW-1:0] first_idx;
  logic [7:0]   first_tag;
  logic         is_add, is_write;

  assign hit      = ram_hit_q | dev_hit_q;
  assign first_oh = hit & (~hit + N'(1));
  assign below    = first_oh - N'(1);
  assign above    = ~(below | first_oh);
  assign any_hit  = |hit;
  assign via_ram  = |(first_oh & ram_hit_q);
  assign hi_fits  = |(first_oh & hi_ok_q);
  assign table_full = (dev_bound_q[N-1] == srad_pkg::ALL_ONES);

  always_comb begin
    first_idx = '0;
    first_tag = '0;
    for (int i = 0; i < N; i++) begin
      if (first_oh[i]) begin
        first_idx = first_idx | IW'(i);
        first_tag = first_tag | tag_q[i];
      end
    end
  end

  assign is_add   = (item_q.opcode == srad_pkg::OP_ADD_MAP);
  assign is_write = (item_q.opcode == srad_pkg::OP_WRITE);

  always_comb begin
    out_d     = '0;
    insert_ok = 1'b0;
    if (is_add) begin
      if (item_q.range_lo > item_q.range_hi) begin
        out_d.status = srad_pkg::ST_BAD_RANGE;
      end else if (!any_hit) begin
        out_d.status      = srad_pkg::ST_OVERLAP;
        out_d.entry_index = 4'(IW'(N - 1));
      end else if (!via_ram || !hi_fits || (item_q.range_lo == '0)) begin
        out_d.status      = srad_pkg::ST_OVERLAP;
        out_d.entry_index = 4'(first_idx);
      end else if (table_full) begin
        out_d.status      = srad_pkg::ST_FULL;
        out_d.entry_index = 4'(first_idx);
      end else begin
        out_d.status      = srad_pkg::ST_OK;
        out_d.entry_index = 4'(first_idx);
        insert_ok         = 1'b1;
      end
    end else begin
      if (any_hit) begin
        out_d.status      = srad_pkg::ST_OK;
        out_d.entry_index = 4'(first_idx);
        out_d.to_device   = !via_ram;
        out_d.target_tag  = via_ram ? 8'd0 : first_tag;
      end else begin
        out_d.status = srad_pkg::ST_NOT_MAPPED;
      end
      out_d.route_address = item_q.address;
      out_d.route_size    = item_q.access_size;
      out_d.route_write   = is_write;
      out_d.route_data    = is_write ? item_q.write_data : 32'd0;
    end
  end

  assign sts_o.drop = (item_q.opcode == srad_pkg::OP_RSVD);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !sts_o.drop) out_q <= out_d;
  end

  assign out_item_o = out_q;

  // table: split the covering entry, shift later entries up
  for (genvar g = 0; g < N; g++) begin : g_entry
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ram_bound_q[g] <= srad_pkg::RAM_SIZE_RST - 32'd1;
          dev_bound_q[g] <= srad_pkg::ALL_ONES;
          tag_q[g]       <= '0;
        end else if (cmd_i.reinit) begin
          ram_bound_q[g] <= cfg_data_i - 32'd1;
          dev_bound_q[g] <= srad_pkg::ALL_ONES;
          tag_q[g]       <= '0;
        end else if (cmd_i.commit && insert_ok && first_oh[g]) begin
          ram_bound_q[g] <= item_q.range_lo - 32'd1;
          dev_bound_q[g] <= item_q.range_hi;
          tag_q[g]       <= item_q.device_tag;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          ram_bound_q[g] <= '0;
          dev_bound_q[g] <= '0;
          tag_q[g]       <= '0;
        end else if (cmd_i.reinit) begin
          ram_bound_q[g] <= '0;
          dev_bound_q[g] <= '0;
          tag_q[g]       <= '0;
        end else if (cmd_i.commit && insert_ok) begin
          if (first_oh[g]) begin
            ram_bound_q[g] <= item_q.range_lo - 32'd1;
            dev_bound_q[g] <= item_q.range_hi;
            tag_q[g]       <= item_q.device_tag;
          end else if (above[g]) begin
            ram_bound_q[g] <= ram_bound_q[g-1];
            dev_bound_q[g] <= dev_bound_q[g-1];
            tag_q[g]       <= tag_q[g-1];
          end
        end
      end
    end
  end

endmodule

// ===== design/sorted_range_address_decoder.sv =====
// Top level of the sorted range address decoder.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes read, write and
// add-map words. Each read, write or add word gives one result word on the
// output channel (out_valid_o / out_stall_i / out_item_o); opcode three is
// taken and dropped without a result.
// A word accepted at one edge is compared against all table entries at that
// edge and the hits are registered; the first covering entry is resolved from
// them in the resolve state, and the result goes into the output register
// once that register is free. No new word is taken while an item is in the
// resolve state; the output register lets the next word in while a result
// still waits. When the receiver stalls, the result holds and the item behind
// it waits in the resolve stage.
// Config (cfg_valid_i / cfg_ready_o / cfg_data_i) writes ram_size and
// rebuilds the table; ready is high while no item is in flight.
// Reset (rst_ni, async, active low) loads a 16 MiB RAM map with a device
// span up to all ones in entry 0 and empties the output.
module sorted_range_address_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  srad_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output srad_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i
);

  srad_pkg::ctrl_cmd_t cmd;
  srad_pkg::dp_sts_t   sts;

  srad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srad_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_item_i  (in_item_i),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== design/srad_checker.sv =====
// Port-level checks of the decoder and their bind to the top level.
module srad_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input srad_pkg::out_item_t out_item_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result word changed or dropped");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("new word or config taken while an item is in flight");

  // config write blocks input in the same cycle
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> in_stall_o)
    else $error("config write and input word accepted together");

  a_device_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.to_device |-> out_item_o.status == srad_pkg::ST_OK)
    else $error("device route with failing status");

  a_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == srad_pkg::ST_NOT_MAPPED |->
      !out_item_o.to_device && out_item_o.target_tag == 8'd0
      && out_item_o.entry_index == 4'd0)
    else $error("unmapped access carries a route");

endmodule

bind sorted_range_address_decoder srad_checker u_srad_checker (.*);
